[hw/rtl/ddrm_pkg.sv]
`default_nettype none
package ddrm_pkg;

  localparam int SpdW   = 8;
  localparam int MagW   = 7;
  localparam int RatioW = 9;
  localparam int McandW = 15;
  localparam int ProdW  = MagW + McandW;
  localparam int DvdW   = 14;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [MagW-1:0]   NormalSpeedRst  = 7'd100;
  localparam logic [MagW-1:0]   PreciseSpeedRst = 7'd50;
  localparam logic [MagW-1:0]   AccelStepRst    = 7'd5;
  localparam logic [RatioW-1:0] InnerRatioRst   = 9'd128;
  localparam logic [RatioW-1:0] RatioOne        = 9'd256;
  localparam logic [McandW-1:0] RatioDen        = 15'd32512;
  localparam logic [MagW-1:0]   SpdMax          = 7'd127;

  typedef enum logic [2:0] {
    REG_PRECISE_MODE   = 3'd0,
    REG_NORMAL_SPEED   = 3'd1,
    REG_PRECISE_SPEED  = 3'd2,
    REG_ACCEL_STEP     = 3'd3,
    REG_INNER_RATIO_Q8 = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_WB
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/ddrm_smul.sv]
`default_nettype none
module ddrm_smul import ddrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MagW-1:0]   mplier,
  input  logic [McandW-1:0] mcand,
  output logic              done,
  output logic [ProdW-1:0]  prod
);

  localparam int CntW = $clog2(MagW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [MagW-1:0] mplier_r, mplier_nxt;
  logic [ProdW-1:0] mcand_r, mcand_nxt;
  logic [ProdW-1:0] acc_r, acc_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = CntW'(MagW - 1);
      mplier_nxt = mplier;
      mcand_nxt  = ProdW'(mcand);
      acc_nxt    = '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

[hw/rtl/ddrm_sdiv.sv]
`default_nettype none
module ddrm_sdiv import ddrm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  output logic            done,
  output logic [MagW-1:0] quotient
);

  localparam int CntW = $clog2(DvdW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DvdW-1:0] dvd_r, dvd_nxt;
  logic [DvdW-1:0] quo_r, quo_nxt;
  logic [MagW-1:0] rem_r, rem_nxt;
  logic [MagW:0]   trial;
  logic [MagW:0]   diff;
  logic            fits;

  assign trial = {rem_r, dvd_r[DvdW-1]};
  assign diff  = trial - {1'b0, SpdMax};
  assign fits  = trial >= {1'b0, SpdMax};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DvdW - 1);
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[MagW-1:0] : trial[MagW-1:0];
      quo_nxt = {quo_r[DvdW-2:0], fits};
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[MagW-1:0];

endmodule
`default_nettype wire

[hw/rtl/diff_drive_ramp_mixer.sv]
// Sequencing: a precise in-place turn goes straight to the writeback state; a normal
// in-place turn takes one pass of the bit-serial multiplier, motion takes two, and both
// then run the bit-serial divide by 127 before the writeback state.
// A new request is taken only once the previous one has been written back; the output
// register holds a result while the next request is taken.
// Reset: synchronous active-low rst_n clears the speed state and loads register defaults.
`default_nettype none
module diff_drive_ramp_mixer import ddrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [1:0]       in_heading,
  input  logic signed [SpdW-1:0]  in_turn_rate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SpdW-1:0]  out_left_drive,
  output logic signed [SpdW-1:0]  out_right_drive,
  output logic signed [SpdW-1:0]  out_ramped_speed
);

  logic              precise_r;
  logic [MagW-1:0]   nspd_r;
  logic [MagW-1:0]   pspd_r;
  logic [MagW-1:0]   step_r;
  logic [RatioW-1:0] ratio_r;
  logic              wr_en;
  reg_idx_t          reg_idx;
  logic [RatioW-1:0] ratio_wr;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = reg_idx_t'(paddr[AddrW-1:2]);
  assign ratio_wr = (pwdata[RatioW-1:0] > RatioOne) ? RatioOne : pwdata[RatioW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precise_r <= 1'b0;
      nspd_r    <= NormalSpeedRst;
      pspd_r    <= PreciseSpeedRst;
      step_r    <= AccelStepRst;
      ratio_r   <= InnerRatioRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRECISE_MODE:   precise_r <= pwdata[0];
        REG_NORMAL_SPEED:   nspd_r    <= pwdata[MagW-1:0];
        REG_PRECISE_SPEED:  pspd_r    <= pwdata[MagW-1:0];
        REG_ACCEL_STEP:     step_r    <= pwdata[MagW-1:0];
        REG_INNER_RATIO_Q8: ratio_r   <= ratio_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRECISE_MODE:   prdata = DataW'(precise_r);
      REG_NORMAL_SPEED:   prdata = DataW'(nspd_r);
      REG_PRECISE_SPEED:  prdata = DataW'(pspd_r);
      REG_ACCEL_STEP:     prdata = DataW'(step_r);
      REG_INNER_RATIO_Q8: prdata = DataW'(ratio_r);
      default:            prdata = '0;
    endcase
  end

  // request decode and speed update
  logic                   hpos, hneg, tneg_in, tpos_in;
  logic signed [SpdW-1:0] turn_neg;
  logic [MagW-1:0]        aturn_in;
  logic [MagW-1:0]        sel_spd, goal_mag;
  logic signed [SpdW-1:0] goal, cur0, cur0_neg, cur_new;
  logic [MagW-1:0]        cur0_mag;
  logic signed [SpdW:0]   step_s, sum9;
  logic signed [SpdW-1:0] sum_sat;
  logic                   ramp;

  logic signed [SpdW-1:0] cur_spd_r, cur_spd_nxt;

  assign hpos     = !in_heading[1] && in_heading[0];
  assign hneg     = in_heading[1];
  assign tneg_in  = in_turn_rate[SpdW-1];
  assign tpos_in  = !in_turn_rate[SpdW-1] && (|in_turn_rate[SpdW-2:0]);
  assign turn_neg = -in_turn_rate;
  assign aturn_in = (in_turn_rate == -8'sd128) ? SpdMax :
                    tneg_in ? turn_neg[MagW-1:0] : in_turn_rate[MagW-1:0];

  assign sel_spd  = precise_r ? pspd_r : nspd_r;
  assign goal_mag = (hpos || hneg) ? sel_spd : '0;
  assign goal     = hpos ? $signed({1'b0, sel_spd}) :
                    hneg ? -$signed({1'b0, sel_spd}) : '0;
  assign cur0     = !(hpos || hneg) ? '0 : precise_r ? goal : cur_spd_r;
  assign cur0_neg = -cur0;
  assign cur0_mag = cur0[SpdW-1] ? cur0_neg[MagW-1:0] : cur0[MagW-1:0];
  assign ramp     = cur0_mag < goal_mag;
  assign step_s   = hpos ? $signed({2'b00, step_r}) : -$signed({2'b00, step_r});
  assign sum9     = $signed({cur0[SpdW-1], cur0}) + step_s;
  assign sum_sat  = (sum9 > $signed({2'b00, SpdMax})) ? $signed({1'b0, SpdMax}) :
                    (sum9 < -$signed({2'b00, SpdMax})) ? -$signed({1'b0, SpdMax}) :
                    sum9[SpdW-1:0];
  assign cur_new  = ramp ? sum_sat : goal;

  // sequencer
  state_t                 state_r, state_nxt;
  logic                   dneg_r, tneg_r, tpos_r, rot_r;
  logic [MagW-1:0]        res_mag_r, res_mag_nxt;
  logic                   accept, out_load;
  logic                   mul_start, mul_done, div_start, div_done;
  logic [MagW-1:0]        mul_mplier;
  logic [McandW-1:0]      mul_mcand;
  logic [ProdW-1:0]       mul_prod;
  logic [DvdW-1:0]        div_dvd;
  logic [MagW-1:0]        div_quo;
  logic signed [SpdW-1:0] cur_neg;
  logic [MagW-1:0]        cur_mag;

  assign cur_neg = -cur_spd_r;
  assign cur_mag = cur_spd_r[SpdW-1] ? cur_neg[MagW-1:0] : cur_spd_r[MagW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    accept      = 1'b0;
    out_load    = 1'b0;
    mul_start   = 1'b0;
    mul_mplier  = '0;
    mul_mcand   = '0;
    div_start   = 1'b0;
    div_dvd     = '0;
    res_mag_nxt = res_mag_r;
    cur_spd_nxt = cur_spd_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept      = 1'b1;
          cur_spd_nxt = cur_new;
          mul_mplier  = aturn_in;
          if (cur_new == '0 && precise_r) begin
            res_mag_nxt = pspd_r;
            state_nxt   = ST_WB;
          end else if (cur_new == '0) begin
            mul_start = 1'b1;
            mul_mcand = McandW'(nspd_r);
            state_nxt = ST_MUL2;
          end else begin
            mul_start = 1'b1;
            mul_mcand = McandW'(RatioOne - ratio_r);
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mplier = cur_mag;
          mul_mcand  = RatioDen - mul_prod[McandW-1:0];
          state_nxt  = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = rot_r ? mul_prod[DvdW-1:0] : mul_prod[ProdW-1:ProdW-DvdW];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_mag_nxt = div_quo;
          state_nxt   = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_spd_r <= '0;
    end else begin
      cur_spd_r <= cur_spd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_mag_r <= res_mag_nxt;
    if (accept) begin
      dneg_r <= hneg;
      tneg_r <= tneg_in;
      tpos_r <= tpos_in;
      rot_r  <= (cur_new == '0);
    end
  end

  ddrm_smul u_smul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mplier (mul_mplier),
    .mcand  (mul_mcand),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  ddrm_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // result formation
  logic signed [SpdW-1:0] mag_pos, mag_neg, inner, left_val, right_val;
  logic                   inner_left;

  assign mag_pos    = $signed({1'b0, res_mag_r});
  assign mag_neg    = -mag_pos;
  assign inner      = cur_spd_r[SpdW-1] ? mag_neg : mag_pos;
  assign inner_left = dneg_r ? !tneg_r : tneg_r;

  always_comb begin
    if (rot_r) begin
      left_val  = tpos_r ? mag_pos : tneg_r ? mag_neg : '0;
      right_val = tpos_r ? mag_neg : tneg_r ? mag_pos : '0;
    end else begin
      left_val  = inner_left ? inner : cur_spd_r;
      right_val = inner_left ? cur_spd_r : inner;
    end
  end

  logic                   out_valid_r, out_valid_nxt;
  logic signed [SpdW-1:0] out_left_r, out_right_r, out_ramp_r;

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= left_val;
      out_right_r <= right_val;
      out_ramp_r  <= cur_spd_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_drive   = out_left_r;
  assign out_right_drive  = out_right_r;
  assign out_ramped_speed = out_ramp_r;

`ifndef SYNTHESIS
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_spd_r != -8'sd128) else $error("speed state left the saturated range");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL1 || state_r == ST_MUL2))
    else $error("multiplier finished outside a multiply phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider finished outside divide phase");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second request taken while busy");
`endif

endmodule
`default_nettype wire
